>>> hdl/dslp_pkg.sv
package dslp_pkg;

  localparam int KEEP_BYTES      = 32;
  localparam int VAL_W           = KEEP_BYTES * 8;
  localparam int WORD_W          = 64;
  localparam int WORD_COUNT      = 8;
  localparam int IDX_W           = 3;
  localparam int BC_W            = 24;
  localparam int LL_W            = 7;
  localparam int LBC_W           = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QCNT_W          = 2;

  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;
  localparam logic [LL_W-1:0] LENX_LIMIT = 7'd4;
  localparam logic [IDX_W-1:0] LAST_IDX  = 3'd7;

  typedef enum logic [12:0] {
    PH_SEQ_TAG  = 13'b0000000000001,
    PH_SEQ_LEN  = 13'b0000000000010,
    PH_SEQ_SKIP = 13'b0000000000100,
    PH_R_TAG    = 13'b0000000001000,
    PH_R_LEN    = 13'b0000000010000,
    PH_R_LENX   = 13'b0000000100000,
    PH_R_VAL    = 13'b0000001000000,
    PH_S_TAG    = 13'b0000010000000,
    PH_S_LEN    = 13'b0000100000000,
    PH_S_LENX   = 13'b0001000000000,
    PH_S_VAL    = 13'b0010000000000,
    PH_DONE     = 13'b0100000000000,
    PH_ERR      = 13'b1000000000000
  } phase_t;

  // One finished signature as it waits between front and back.
  typedef struct packed {
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] s_val;
    logic             ok;
    logic             too_long;
  } rec_t;

  // Queue handshake seen by the back end.
  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

endpackage

>>> hdl/dslp_stream_if.sv
interface dslp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface dslp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sig_word;
  logic [2:0]  word_index;
  logic        format_ok;
  logic        too_long;
  logic        last_word;
  modport source (output valid, output sig_word, output word_index, output format_ok,
                  output too_long, output last_word, input ready);
  modport sink   (input valid, input sig_word, input word_index, input format_ok,
                  input too_long, input last_word, output ready);
endinterface

>>> hdl/dslp_front.sv
module dslp_front #(
  parameter int VALUE_BYTES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           q_full,
  output logic           push,
  output dslp_pkg::rec_t push_rec
);
  import dslp_pkg::*;

  localparam int SC_W = $clog2(VALUE_BYTES + 2);
  localparam logic [SC_W-1:0] SC_LIM = SC_W'(VALUE_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [LL_W-1:0]   ll_r, ll_nxt;
  logic [LBC_W-1:0]  lbc_r, lbc_nxt;
  logic [SC_W-1:0]   sc_r, sc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [VAL_W-1:0]  r_r, r_nxt, s_r, s_nxt;
  logic              is_s;
  logic              fire;
  logic              ok;

  function automatic phase_t value_entry(logic s_side, logic [BC_W-1:0] n);
    if (n == '0) value_entry = s_side ? PH_DONE : PH_S_TAG;
    else         value_entry = s_side ? PH_S_VAL : PH_R_VAL;
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign is_s     = (phase_r == PH_S_LEN) || (phase_r == PH_S_LENX) || (phase_r == PH_S_VAL);

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    ll_nxt    = ll_r;
    lbc_nxt   = lbc_r;
    sc_nxt    = sc_r;
    ovf_nxt   = ovf_r;
    r_nxt     = r_r;
    s_nxt     = s_r;
    unique case (phase_r)
      PH_SEQ_TAG: phase_nxt = (in_byte == SEQ_TAG) ? PH_SEQ_LEN : PH_ERR;
      PH_SEQ_LEN: begin
        if (in_byte[7] && in_byte[6:0] != '0) begin
          ll_nxt    = in_byte[6:0];
          phase_nxt = PH_SEQ_SKIP;
        end else begin
          phase_nxt = PH_R_TAG;
        end
      end
      PH_SEQ_SKIP: begin
        ll_nxt = ll_r - 7'd1;
        if (ll_nxt == '0) phase_nxt = PH_R_TAG;
      end
      PH_R_TAG: phase_nxt = (in_byte == INT_TAG) ? PH_R_LEN : PH_ERR;
      PH_S_TAG: phase_nxt = (in_byte == INT_TAG) ? PH_S_LEN : PH_ERR;
      PH_R_LEN, PH_S_LEN: begin
        if (!in_byte[7]) begin
          bc_nxt    = BC_W'(in_byte[6:0]);
          sc_nxt    = '0;
          phase_nxt = value_entry(is_s, bc_nxt);
        end else if (in_byte[6:0] == '0) begin
          bc_nxt    = '0;
          sc_nxt    = '0;
          phase_nxt = value_entry(is_s, bc_nxt);
        end else begin
          ll_nxt    = in_byte[6:0];
          lbc_nxt   = '0;
          bc_nxt    = '0;
          phase_nxt = is_s ? PH_S_LENX : PH_R_LENX;
        end
      end
      PH_R_LENX, PH_S_LENX: begin
        if (lbc_r == '0 && in_byte == 8'h00) begin
          // skip a leading zero length byte
          ll_nxt = ll_r - 7'd1;
          if (ll_nxt == '0) begin
            sc_nxt    = '0;
            phase_nxt = value_entry(is_s, bc_nxt);
          end
        end else if (lbc_r == '0 && ll_r >= LENX_LIMIT) begin
          phase_nxt = PH_ERR;
        end else begin
          bc_nxt  = {bc_r[BC_W-9:0], in_byte};
          lbc_nxt = lbc_r + 2'd1;
          ll_nxt  = ll_r - 7'd1;
          if (ll_nxt == '0) begin
            sc_nxt    = '0;
            phase_nxt = value_entry(is_s, bc_nxt);
          end
        end
      end
      PH_R_VAL, PH_S_VAL: begin
        if (sc_r != '0 || in_byte != 8'h00) begin
          if (is_s) s_nxt = {s_r[VAL_W-9:0], in_byte};
          else      r_nxt = {r_r[VAL_W-9:0], in_byte};
          if (sc_r <= SC_LIM) sc_nxt = sc_r + SC_W'(1);
          if (sc_nxt > SC_LIM) ovf_nxt = 1'b1;
        end
        bc_nxt = bc_r - BC_W'(1);
        if (bc_nxt == '0) phase_nxt = is_s ? PH_DONE : PH_S_TAG;
      end
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_ERR;
    endcase
  end

  assign ok                = (phase_nxt == PH_DONE);
  assign push              = fire && in_last;
  assign push_rec.r_val    = r_nxt;
  assign push_rec.s_val    = s_nxt;
  assign push_rec.ok       = ok;
  assign push_rec.too_long = ok && ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r <= PH_SEQ_TAG;
      bc_r    <= '0;
      ll_r    <= '0;
      lbc_r   <= '0;
      sc_r    <= '0;
      ovf_r   <= 1'b0;
      r_r     <= '0;
      s_r     <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      ll_r    <= ll_nxt;
      lbc_r   <= lbc_nxt;
      sc_r    <= sc_nxt;
      ovf_r   <= ovf_nxt;
      r_r     <= r_nxt;
      s_r     <= s_nxt;
    end
  end

endmodule

>>> hdl/dslp_queue.sv
module dslp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dslp_pkg::rec_t     push_rec,
  input  logic               pop,
  output dslp_pkg::rec_t     head_rec,
  output dslp_pkg::q_stat_t  stat
);
  import dslp_pkg::*;

  rec_t              ent_r [QUEUE_DEPTH];
  logic              wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head_rec        = ent_r[rd_ptr_r];
  assign stat.head_valid = (cnt_r != '0);
  assign stat.full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hdl/dslp_back.sv
module dslp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dslp_pkg::rec_t          head_rec,
  input  dslp_pkg::q_stat_t       stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             out_sig_word,
  output logic [2:0]              out_word_index,
  output logic                    out_format_ok,
  output logic                    out_too_long,
  output logic                    out_last_word
);
  import dslp_pkg::*;

  localparam int RS_W = 2 * VAL_W;

  logic [IDX_W-1:0]  idx_r;
  logic              valid_r;
  logic [WORD_W-1:0] word_r;
  logic [IDX_W-1:0]  widx_r;
  logic              ok_r, tl_r, lw_r;
  logic [RS_W-1:0]   rs;
  logic [WORD_W-1:0] word_sel;
  logic              load;

  assign rs   = {head_rec.r_val, head_rec.s_val};
  assign load = stat.head_valid && (!valid_r || out_ready);
  assign pop  = load && (idx_r == LAST_IDX);

  always_comb begin
    word_sel = '0;
    for (int k = 0; k < WORD_COUNT; k++) begin
      if (idx_r == IDX_W'(k)) word_sel = rs[RS_W-1-WORD_W*k -: WORD_W];
    end
    if (!head_rec.ok || head_rec.too_long) word_sel = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= idx_r + IDX_W'(1);
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_sel;
      widx_r <= idx_r;
      ok_r   <= head_rec.ok;
      tl_r   <= head_rec.too_long;
      lw_r   <= (idx_r == LAST_IDX);
    end
  end

  assign out_valid      = valid_r;
  assign out_sig_word   = word_r;
  assign out_word_index = widx_r;
  assign out_format_ok  = ok_r;
  assign out_too_long   = tl_r;
  assign out_last_word  = lw_r;

endmodule

>>> hdl/der_signature_lax_parser_unit.sv
// Lenient DER parser for ECDSA signatures. Bytes enter on in_s, one
// transaction per cycle, with in_last on the final byte; the front end walks
// the sequence and integer headers and shifts the significant value bytes of
// R and S into two 32-byte registers. When the last byte is taken, the
// parsed R||S is queued (two signatures deep) and the back end sends eight
// 64-bit words on out_m, one transaction per cycle while out_m.ready is high,
// big-endian, R in words 0..3 and S in 4..7, each tagged with format_ok and
// too_long. Words are zero on a format error or when a value has more than
// VALUE_BYTES significant bytes. Input throughput is one byte per cycle; the
// output side sends eight words per signature, and in_s.ready drops only
// while two finished signatures are still waiting in the queue. Parser state
// clears after every last byte, so the next byte starts a new signature.
module der_signature_lax_parser_unit #(
  parameter int VALUE_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  dslp_in_if.sink       in_s,
  dslp_out_if.source    out_m
);
  import dslp_pkg::*;

  logic    push;
  logic    pop;
  rec_t    push_rec;
  rec_t    head_rec;
  q_stat_t q_stat;
  logic    front_ready;

  // Front end: accept bytes, track header phase, collect R and S.
  dslp_front #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (front_ready),
    .in_byte  (in_s.in_byte),
    .in_last  (in_s.in_last),
    .q_full   (q_stat.full),
    .push     (push),
    .push_rec (push_rec)
  );

  assign in_s.ready = front_ready;

  // Hold finished signatures so the front end keeps taking bytes.
  dslp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  // Back end: advance through the eight words of the head entry.
  dslp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_rec       (head_rec),
    .stat           (q_stat),
    .pop            (pop),
    .out_valid      (out_m.valid),
    .out_ready      (out_m.ready),
    .out_sig_word   (out_m.sig_word),
    .out_word_index (out_m.word_index),
    .out_format_ok  (out_m.format_ok),
    .out_too_long   (out_m.too_long),
    .out_last_word  (out_m.last_word)
  );

endmodule

>>> hdl/dslp_checker.sv
module dslp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] sig_word,
  input logic [2:0]  word_index,
  input logic        format_ok,
  input logic        too_long,
  input logic        last_word
);

  // Stalled output holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sig_word) && $stable(word_index)
      && $stable(format_ok) && $stable(too_long) && $stable(last_word))
    else $error("output changed while stalled");

  // Words of one signature follow each other without a gap.
  a_word_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=> out_valid
      && word_index == 3'($past(word_index) + 3'd1)
      && format_ok == $past(format_ok) && too_long == $past(too_long))
    else $error("word run broken");

  // Rejected or oversized signatures carry zero words.
  a_zero_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!format_ok || too_long) |-> sig_word == 64'd0
      && (format_ok || !too_long))
    else $error("nonzero word on bad signature");

  // Reset empties the output side.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind der_signature_lax_parser_unit dslp_checker u_dslp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_m.valid),
  .out_ready  (out_m.ready),
  .sig_word   (out_m.sig_word),
  .word_index (out_m.word_index),
  .format_ok  (out_m.format_ok),
  .too_long   (out_m.too_long),
  .last_word  (out_m.last_word)
);

>>> tb/sv/dslp_sig_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the parser. Each input transaction advances its own
// model of the lenient DER walk; a last byte queues the eight expected words of
// compact R||S, and each output transaction is compared against the oldest one.
module dslp_sig_checker #(
  parameter int VALUE_BYTES = 32
) (
  input  logic clk,
  input  logic rst_n,
  dslp_in_if   in_mon,
  dslp_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   words_checked
);
  import dslp_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] sig_word;
    logic [IDX_W-1:0]  word_index;
    logic              format_ok;
    logic              too_long;
    logic              last_word;
  } sig_word_t;

  sig_word_t        expected_words[$];

  phase_t           ph;
  logic [BC_W-1:0]  due_len;
  int unsigned      lenx_taken;
  logic [LL_W-1:0]  lenx_left;
  logic [VAL_W-1:0] r_acc;
  logic [VAL_W-1:0] s_acc;
  int unsigned      sig_cnt;
  bit               ovf;
  bit               err;

  task automatic clear_parser();
    ph         = PH_SEQ_TAG;
    due_len    = '0;
    lenx_taken = 0;
    lenx_left  = '0;
    r_acc      = '0;
    s_acc      = '0;
    sig_cnt    = 0;
    ovf        = 1'b0;
    err        = 1'b0;
  endtask

  task automatic start_value(input bit is_s);
    sig_cnt = 0;
    if (due_len == '0) begin
      ph = is_s ? PH_DONE : PH_S_TAG;
    end else begin
      ph = is_s ? PH_S_VAL : PH_R_VAL;
    end
  endtask

  task automatic take_length(input bit is_s, input logic [7:0] b);
    if (!b[7]) begin
      due_len = {{(BC_W-7){1'b0}}, b[6:0]};
      start_value(is_s);
    end else if (b[6:0] == 7'd0) begin
      due_len = '0;
      start_value(is_s);
    end else begin
      lenx_left  = b[6:0];
      lenx_taken = 0;
      due_len    = '0;
      ph         = is_s ? PH_S_LENX : PH_R_LENX;
    end
  endtask

  // Skip leading zero length bytes; too many significant ones is a format error.
  task automatic take_ext_length(input bit is_s, input logic [7:0] b);
    if (lenx_taken == 0 && b == 8'd0) begin
      lenx_left = lenx_left - 1'b1;
      if (lenx_left == '0) start_value(is_s);
    end else if (lenx_taken == 0 && lenx_left >= LENX_LIMIT) begin
      ph  = PH_ERR;
      err = 1'b1;
    end else begin
      due_len    = {due_len[BC_W-9:0], b};
      lenx_taken = lenx_taken + 1;
      lenx_left  = lenx_left - 1'b1;
      if (lenx_left == '0) start_value(is_s);
    end
  endtask

  // Drop leading zeros, shift significant bytes in, flag oversize values.
  task automatic take_value_byte(input bit is_s, input logic [7:0] b);
    if (sig_cnt != 0 || b != 8'd0) begin
      if (is_s) s_acc = {s_acc[VAL_W-9:0], b};
      else      r_acc = {r_acc[VAL_W-9:0], b};
      if (sig_cnt <= VALUE_BYTES) sig_cnt = sig_cnt + 1;
      if (sig_cnt > VALUE_BYTES) ovf = 1'b1;
    end
    due_len = due_len - 1'b1;
    if (due_len == '0) ph = is_s ? PH_DONE : PH_S_TAG;
  endtask

  task automatic queue_compact_sig();
    logic             ok;
    logic             tl;
    logic [VAL_W-1:0] val;
    sig_word_t        w;
    ok = (ph == PH_DONE) && !err;
    tl = ok && ovf;
    for (int k = 0; k < WORD_COUNT; k++) begin
      val          = (k < 4) ? r_acc : s_acc;
      w.sig_word   = (ok && !tl) ? val[(VAL_W - 1 - WORD_W * (k % 4)) -: WORD_W] : '0;
      w.word_index = k[IDX_W-1:0];
      w.format_ok  = ok;
      w.too_long   = tl;
      w.last_word  = (k[IDX_W-1:0] == LAST_IDX);
      expected_words = {expected_words, w};
    end
  endtask

  task automatic parse_der_byte(input logic [7:0] b, input logic lst);
    case (ph)
      PH_SEQ_TAG: ph = (b == SEQ_TAG) ? PH_SEQ_LEN : PH_ERR;
      PH_SEQ_LEN: begin
        if (b[7] && b[6:0] != 7'd0) begin
          lenx_left = b[6:0];
          ph        = PH_SEQ_SKIP;
        end else begin
          ph = PH_R_TAG;
        end
      end
      PH_SEQ_SKIP: begin
        lenx_left = lenx_left - 1'b1;
        if (lenx_left == '0) ph = PH_R_TAG;
      end
      PH_R_TAG:  ph = (b == INT_TAG) ? PH_R_LEN : PH_ERR;
      PH_R_LEN:  take_length(1'b0, b);
      PH_R_LENX: take_ext_length(1'b0, b);
      PH_R_VAL:  take_value_byte(1'b0, b);
      PH_S_TAG:  ph = (b == INT_TAG) ? PH_S_LEN : PH_ERR;
      PH_S_LEN:  take_length(1'b1, b);
      PH_S_LENX: take_ext_length(1'b1, b);
      PH_S_VAL:  take_value_byte(1'b1, b);
      PH_DONE:   ;
      default:   ph = PH_ERR;
    endcase
    if (ph == PH_ERR) err = 1'b1;
    if (lst) begin
      queue_compact_sig();
      clear_parser();
    end
  endtask

  task automatic check_result_word();
    sig_word_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected result word: index %0d word %h", out_mon.word_index, out_mon.sig_word);
      fail_count = fail_count + 1;
    end else begin
      e = expected_words.pop_front();
      words_checked = words_checked + 1;
      if (out_mon.sig_word !== e.sig_word) begin
        $error("sig_word: expected %h, got %h", e.sig_word, out_mon.sig_word);
        fail_count = fail_count + 1;
      end
      if (out_mon.word_index !== e.word_index) begin
        $error("word_index: expected %0d, got %0d", e.word_index, out_mon.word_index);
        fail_count = fail_count + 1;
      end
      if (out_mon.format_ok !== e.format_ok) begin
        $error("format_ok: expected %b, got %b", e.format_ok, out_mon.format_ok);
        fail_count = fail_count + 1;
      end
      if (out_mon.too_long !== e.too_long) begin
        $error("too_long: expected %b, got %b", e.too_long, out_mon.too_long);
        fail_count = fail_count + 1;
      end
      if (out_mon.last_word !== e.last_word) begin
        $error("last_word: expected %b, got %b", e.last_word, out_mon.last_word);
        fail_count = fail_count + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_words.delete();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      // Predict first, so a word can never be checked against a stale queue.
      if (in_mon.valid && in_mon.ready) parse_der_byte(in_mon.in_byte, in_mon.in_last);
      if (out_mon.valid && out_mon.ready) check_result_word();
    end
    pending = expected_words.size();
  end

endmodule

>>> tb/sv/der_signature_lax_parser_unit_tb.sv
`timescale 1ns / 1ps

module der_signature_lax_parser_unit_tb;
  import dslp_pkg::*;

  logic clk;
  logic rst_n;

  dslp_in_if  in_ch();
  dslp_out_if out_ch();

  int fail_count;
  int pending;
  int words_checked;

  // Bytes of the signature being built, plus where its two integer tags sit.
  logic [7:0] sig_q[$];
  int         r_tag_pos;
  int         s_tag_pos;
  int         sigs_sent;
  int         bytes_sent;
  bit         quiet_sender;

  der_signature_lax_parser_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  dslp_sig_checker u_sig_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop in case the block hangs; normal runs finish well inside this.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Signature construction
  // ---------------------------------------------------------------------------

  // Append one byte to the signature being built.
  task automatic add_byte(input logic [7:0] b);
    sig_q = {sig_q, b};
  endtask

  // Append a DER length: short form, or long form with optional leading zero
  // length bytes in front of the big-endian count.
  task automatic add_len(input int n, input bit long_form, input int len_zeros);
    int nb;
    if (!long_form) begin
      add_byte(n[7:0]);
    end else begin
      nb = (n == 0) ? 0 : (n < 256) ? 1 : (n < 65536) ? 2 : 3;
      add_byte(8'h80 | 8'(len_zeros + nb));
      repeat (len_zeros) add_byte(8'h00);
      for (int i = nb - 1; i >= 0; i--) add_byte(8'(n >> (8 * i)));
    end
  endtask

  // Append one INTEGER: tag, length, leading zero bytes, then significant
  // bytes. A negative pattern means random content with a nonzero first byte.
  task automatic add_integer(input int zeros, input int sig, input int pattern,
                             input bit long_form, input int len_zeros, output int tag_pos);
    tag_pos = sig_q.size();
    add_byte(INT_TAG);
    add_len(zeros + sig, long_form, len_zeros);
    repeat (zeros) add_byte(8'h00);
    for (int i = 0; i < sig; i++) begin
      if (pattern >= 0)  add_byte(pattern[7:0]);
      else if (i == 0)   add_byte(8'($urandom_range(1, 255)));
      else               add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Sequence header; the length is ignored, a long form only adds skip bytes.
  task automatic start_seq(input int skip);
    sig_q.delete();
    add_byte(SEQ_TAG);
    if (skip == 0) begin
      add_byte($urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(0, 127)));
    end else begin
      add_byte(8'h80 | 8'(skip));
      repeat (skip) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_sig(input int r_zeros, input int r_sig, input int r_pat,
                           input int s_zeros, input int s_sig, input int s_pat,
                           input bit long_form, input int len_zeros, input int skip,
                           input int trailing);
    start_seq(skip);
    add_integer(r_zeros, r_sig, r_pat, long_form, len_zeros, r_tag_pos);
    add_integer(s_zeros, s_sig, s_pat, long_form, len_zeros, s_tag_pos);
    repeat (trailing) add_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Idle first if gap is positive, then present one byte and hold it until accepted.
  // Everything changes on the falling edge, one assignment per signal.
  task automatic send_byte(input logic [7:0] b, input logic lst, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    in_ch.in_last = lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  // Send the built signature, last flag on its final byte. A quarter of the
  // signatures go out back to back to keep the pipe full.
  task automatic send_sig();
    quiet_sender = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < sig_q.size(); i++) begin
      send_byte(sig_q[i], i == sig_q.size() - 1, quiet_sender ? 0 : $urandom_range(0, 12));
    end
    sigs_sent++;
  endtask

  // Result sink: insert a random stall, possibly none, before each transaction,
  // with occasional stall-free stretches.
  initial begin
    int stall;
    int calm;
    calm = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (calm > 0) begin
        stall = 0;
        calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        calm  = $urandom_range(8, 40);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    int kind;
    int pick;
    int r_sig;
    int s_sig;
    int n;

    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    sigs_sent     = 0;
    bytes_sent    = 0;
    rst_n         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // --- Directed signatures ---

    // Smallest well-formed signature.
    sig_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
    send_sig();
    // Full 32-byte R of all ones; S behind a leading zero byte.
    build_sig(0, 32, 8'hFF, 1, 3, -1, 1'b1, 0, 0, 0);
    send_sig();
    // R one byte too long: words zeroed, too_long set.
    build_sig(0, 33, -1, 0, 4, -1, 1'b0, 0, 0, 0);
    send_sig();
    // S two bytes too long, behind leading zeros.
    build_sig(0, 5, -1, 2, 34, -1, 1'b1, 1, 1, 0);
    send_sig();
    // Long sequence length with skip bytes; empty R (short 0) and empty S (0x80).
    build_sig(0, 0, -1, 0, 0, -1, 1'b0, 0, 2, 0);
    sig_q[sig_q.size() - 1] = 8'h80;
    send_sig();
    // Leading zero length bytes before a single significant one.
    build_sig(0, 5, -1, 0, 7, -1, 1'b1, 3, 0, 0);
    send_sig();
    // All-zero long length means an empty value.
    sig_q = '{8'h30, 8'h10, 8'h02, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h02, 8'h01, 8'h7F};
    send_sig();
    // Four significant length bytes: format error.
    sig_q = '{8'h30, 8'h20, 8'h02, 8'h84, 8'h01, 8'h02, 8'h03, 8'h04, 8'h11, 8'h22};
    send_sig();
    // Four significant length bytes after a leading zero: still an error.
    sig_q = '{8'h30, 8'h20, 8'h02, 8'h85, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h55};
    send_sig();
    // Huge three-byte length, stream ends early: truncated.
    sig_q = '{8'h30, 8'h20, 8'h02, 8'h84, 8'h00, 8'h01, 8'h00, 8'h00};
    repeat (10) add_byte(8'($urandom_range(0, 255)));
    send_sig();
    // Wrong sequence tag.
    build_sig(0, 3, -1, 0, 3, -1, 1'b0, 0, 0, 0);
    sig_q[0] = 8'h31;
    send_sig();
    // Wrong R tag.
    build_sig(0, 3, -1, 0, 3, -1, 1'b0, 0, 0, 0);
    sig_q[r_tag_pos] = 8'h03;
    send_sig();
    // Wrong S tag.
    build_sig(0, 3, -1, 0, 3, -1, 1'b0, 0, 0, 0);
    sig_q[s_tag_pos] = 8'h00;
    send_sig();
    // Trailing bytes after S are ignored.
    build_sig(0, 3, -1, 0, 3, -1, 1'b0, 0, 0, 2);
    add_byte(8'hFF);
    send_sig();
    // One-byte signatures.
    sig_q = '{8'h30};
    send_sig();
    sig_q = '{8'hFF};
    send_sig();
    // Zero R value and a small S.
    build_sig(5, 0, -1, 0, 1, 8'h80, 1'b0, 0, 0, 0);
    send_sig();

    // --- Random signatures: mostly well-formed, the rest broken or noise ---
    n = 0;
    while (bytes_sent < 340 || n < 2) begin
      pick  = $urandom_range(0, 9);
      r_sig = (pick < 7) ? $urandom_range(0, 8) : (pick < 9) ? $urandom_range(9, 32)
                                                             : $urandom_range(33, 34);
      pick  = $urandom_range(0, 9);
      s_sig = (pick < 7) ? $urandom_range(0, 8) : (pick < 9) ? $urandom_range(9, 32)
                                                             : $urandom_range(33, 34);
      build_sig($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0, r_sig, -1,
                $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0, s_sig, -1,
                $urandom_range(0, 9) < 3, $urandom_range(0, 2),
                $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3),
                $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
      if ($urandom_range(0, 3) == 0) begin
        kind = $urandom_range(0, 5);
        case (kind)
          0: sig_q[0]         = sig_q[0] ^ 8'($urandom_range(1, 255));
          1: sig_q[r_tag_pos] = sig_q[r_tag_pos] ^ 8'($urandom_range(1, 255));
          2: sig_q[s_tag_pos] = sig_q[s_tag_pos] ^ 8'($urandom_range(1, 255));
          3: sig_q = sig_q[0:$urandom_range(0, sig_q.size() - 2)];
          4: begin
            sig_q.delete();
            add_byte($urandom_range(0, 1) ? SEQ_TAG : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 15)) add_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            // Oversized long-form R length.
            sig_q = '{SEQ_TAG, 8'h45, INT_TAG};
            pick  = $urandom_range(0, 2);
            add_byte(8'h80 | 8'(4 + pick));
            repeat (pick) add_byte(8'h00);
            add_byte(8'($urandom_range(1, 255)));
            repeat (3 + $urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
      send_sig();
      n++;
    end

    // Drop valid, drain the expected words, then give the back end time to
    // show any stray extra transaction.
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Summary: %0d signatures in %0d byte transactions, %0d result words checked",
             sigs_sent, bytes_sent, words_checked);
    $display("  (long/short lengths, oversize values, bad tags, truncation, noise)");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
